### sv/symbol_name_bucket_hash_defines.svh
// ----------------------------------------------------------------------------
// symbol_name_bucket_hash assertion macros
// Concurrent assertion wrappers on clk and arst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_NAME_BUCKET_HASH_DEFINES_SVH
`define SYMBOL_NAME_BUCKET_HASH_DEFINES_SVH

`ifndef SYNTHESIS
`define SHBH_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shbh assertion failed");
`define SHBH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shbh assertion failed");
`else
`define SHBH_ASSERT_IMPLY(lbl, ante, cons)
`define SHBH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/shbh_pkg.sv
// ----------------------------------------------------------------------------
// shbh_pkg
// Shared types and constants of the symbol name bucket hash.
// ----------------------------------------------------------------------------
package shbh_pkg;

	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [31:0] OR_MASK           = 32'h2020_2020;
	localparam logic [31:0] BUCKET_COUNT_RST  = 32'd262143;
	localparam logic        REG_BUCKET_COUNT  = 1'b0;

	// one closed name waiting for its modulo
	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] divisor;
	} shbh_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} shbh_fifo_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} shbh_back_state_t;

endpackage

### sv/shbh_byte_if.sv
// ----------------------------------------------------------------------------
// shbh_byte_if
// Byte channel: one name byte or end marker per beat.
// ----------------------------------------------------------------------------
interface shbh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       byte_valid;
	logic       end_of_name;

	modport source (output valid, output char_byte, output byte_valid,
		output end_of_name, input ready);
	modport sink (input valid, input char_byte, input byte_valid,
		input end_of_name, output ready);
endinterface

### sv/shbh_result_if.sv
// ----------------------------------------------------------------------------
// shbh_result_if
// Result channel: bucket index and mixed hash, one per closed name.
// ----------------------------------------------------------------------------
interface shbh_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] bucket_index;
	logic [31:0] mixed_hash;

	modport source (output valid, output bucket_index, output mixed_hash, input ready);
	modport sink (input valid, input bucket_index, input mixed_hash, output ready);
endinterface

### sv/shbh_front.sv
// ----------------------------------------------------------------------------
// shbh_front
// Byte accumulator: folds bytes into the hash and queues closed names.
// ----------------------------------------------------------------------------
module shbh_front (
	input  logic                     clk,
	input  logic                     arst_n,
	shbh_byte_if.sink                sym,
	input  logic [31:0]              bucket_count,
	input  shbh_pkg::shbh_fifo_stat_t stat,
	output logic                     push,
	output shbh_pkg::shbh_job_t      job
);
	import shbh_pkg::*;

	localparam logic [1:0] LANE_FIRST  = 2'd0;
	localparam logic [1:0] LANE_SECOND = 2'd1;
	localparam logic [1:0] LANE_THIRD  = 2'd2;
	localparam logic [1:0] LANE_FOURTH = 2'd3;

	logic [31:0] acc_q, acc_n;
	logic [1:0]  lane_q, lane_n;
	logic [7:0]  pend_q, pend_n;
	logic        accept;
	logic [31:0] folded, masked, mix1;

	assign sym.ready = !stat.full;
	assign accept    = sym.valid && sym.ready;

	always_comb begin
		acc_n  = acc_q;
		lane_n = lane_q;
		pend_n = pend_q;
		if (sym.byte_valid) begin
			unique case (lane_q)
				LANE_FIRST:  acc_n = acc_q ^ {24'd0, sym.char_byte};
				LANE_SECOND: acc_n = acc_q ^ {16'd0, sym.char_byte, 8'd0};
				LANE_THIRD:  pend_n = sym.char_byte;
				LANE_FOURTH: begin
					acc_n  = acc_q ^ {sym.char_byte, pend_q, 16'd0};
					pend_n = 8'd0;
				end
				default: acc_n = acc_q;
			endcase
			lane_n = lane_q + 2'd1;
		end
	end

	// odd tail byte drops into lane 0 on close
	assign folded = (lane_n == LANE_FOURTH) ? (acc_n ^ {24'd0, pend_n}) : acc_n;
	assign masked = folded | OR_MASK;
	assign mix1   = masked ^ (masked >> 11);

	assign push        = accept && sym.end_of_name;
	assign job.hash    = mix1 ^ (mix1 >> 16);
	assign job.divisor = bucket_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			lane_q <= LANE_FIRST;
			pend_q <= '0;
		end else if (accept) begin
			if (sym.end_of_name) begin
				acc_q  <= '0;
				lane_q <= LANE_FIRST;
				pend_q <= '0;
			end else begin
				acc_q  <= acc_n;
				lane_q <= lane_n;
				pend_q <= pend_n;
			end
		end
	end

endmodule

### sv/shbh_fifo.sv
// ----------------------------------------------------------------------------
// shbh_fifo
// Short job queue between the byte front end and the modulo unit.
// ----------------------------------------------------------------------------
module shbh_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  shbh_pkg::shbh_job_t       job_in,
	input  logic                      pop,
	output shbh_pkg::shbh_job_t       job_out,
	output shbh_pkg::shbh_fifo_stat_t stat
);
	import shbh_pkg::*;

	shbh_job_t               entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    do_push, do_pop;

	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign job_out    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/shbh_back.sv
// ----------------------------------------------------------------------------
// shbh_back
// Modulo unit: restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module shbh_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  shbh_pkg::shbh_fifo_stat_t stat,
	input  shbh_pkg::shbh_job_t       job,
	output logic                      pop,
	shbh_result_if.source             res
);
	import shbh_pkg::*;

	shbh_back_state_t state_q, state_n;
	logic [31:0] hash_q, div_q, dvd_q, rem_q;
	logic [4:0]  cnt_q;
	logic [31:0] bucket_index_q, mixed_hash_q;
	logic        out_valid_q;
	logic        slot_free, step, load_out;
	logic [32:0] rem_try, diff;
	logic        ge;
	logic [31:0] rem_n;

	assign slot_free = !out_valid_q || res.ready;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: if (!stat.empty) state_n = BK_DIV;
			BK_DIV:  if (cnt_q == 5'd31) state_n = BK_DONE;
			BK_DONE: if (slot_free) state_n = BK_IDLE;
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !stat.empty;
			BK_DIV:  step = 1'b1;
			BK_DONE: load_out = slot_free;
			default: pop = 1'b0;
		endcase
	end

	assign rem_try = {rem_q, dvd_q[31]};
	assign diff    = rem_try - {1'b0, div_q};
	assign ge      = (rem_try >= {1'b0, div_q});
	assign rem_n   = ge ? diff[31:0] : rem_try[31:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			hash_q <= job.hash;
			div_q  <= job.divisor;
			dvd_q  <= job.hash;
			rem_q  <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_n;
		end
		if (load_out) begin
			// a zero bucket count stands for 2^32
			bucket_index_q <= (div_q == '0) ? hash_q : rem_q;
			mixed_hash_q   <= hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.bucket_index = bucket_index_q;
	assign res.mixed_hash   = mixed_hash_q;

endmodule

### sv/symbol_name_bucket_hash.sv
// Bytes: one beat per cycle unless the job queue is full; the hash of a closing
// beat is ready at that edge. Results: a closed name is queued, popped in BK_IDLE,
// divided in BK_DIV and put on the result beat in BK_DONE once the slot is free;
// the modulo unit takes one job at a time; a 2-entry job queue lets bytes run on.
// Reset (arst_n, async): name state and queue clear, bucket_count = 262143.
// ----------------------------------------------------------------------------
// symbol_name_bucket_hash
// Symbol name hash with bucket reduction, APB register for bucket count.
// ----------------------------------------------------------------------------
`include "symbol_name_bucket_hash_defines.svh"

module symbol_name_bucket_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	shbh_byte_if.sink   sym,
	shbh_result_if.source res
);
	import shbh_pkg::*;

	logic [31:0]     bucket_count_q;
	logic            cfg_write;
	logic            push, pop;
	shbh_job_t       job_in, job_out;
	shbh_fifo_stat_t fstat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);
	assign prdata    = (paddr[2] == REG_BUCKET_COUNT) ? bucket_count_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RST;
		end else if (cfg_write) begin
			bucket_count_q <= pwdata;
		end
	end

	shbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sym          (sym),
		.bucket_count (bucket_count_q),
		.stat         (fstat),
		.push         (push),
		.job          (job_in)
	);

	shbh_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.stat    (fstat)
	);

	shbh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (fstat),
		.job    (job_out),
		.pop    (pop),
		.res    (res)
	);

	`SHBH_ASSERT_IMPLY(a_no_push_full, push, !fstat.full)
	`SHBH_ASSERT_IMPLY(a_no_pop_empty, pop, !fstat.empty)
	`SHBH_ASSERT_NEXT(a_push_fills, push && fstat.empty && !pop, !fstat.empty)
	`SHBH_ASSERT_IMPLY(a_index_range, res.valid && |bucket_count_q, res.bucket_index < bucket_count_q)

endmodule
